>>> rtl/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types and constants of the bounded ordered list engine: operation
// and status codes, controller states, and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bole_pkg;

    // Field widths fixed by the item format.
    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int CODE_W  = 3;

    // Upper bound on results produced by one item, and the width of its counter.
    localparam int MAX_RESULTS = 16;
    localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

    // Operation codes carried with every input beat.
    typedef enum logic [CODE_W-1:0] {
        OP_PUSH_FRONT   = 3'd0,
        OP_PUSH_BACK    = 3'd1,
        OP_INSERT_AFTER = 3'd2,
        OP_POP_FRONT    = 3'd3,
        OP_POP_BACK     = 3'd4,
        OP_DELETE_AFTER = 3'd5,
        OP_SEARCH       = 3'd6,
        OP_READ_OUT     = 3'd7
    } op_t;

    // Result status codes.
    typedef enum logic [CODE_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_BADPOS   = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    // What the decoded item asks of the datapath.
    typedef enum logic [1:0] {
        ACT_ERR,
        ACT_INSERT,
        ACT_REMOVE,
        ACT_SCAN
    } action_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOVE,
        S_SCAN_CHK,
        S_SCAN_WAIT,
        S_FINAL,
        S_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic emit_err;
        logic move_start;
        logic move;
        logic scan_read;
        logic scan_step;
        logic emit_final;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_t act;
        logic    move_done;
        logic    out_busy;
        logic    scan_done;
        logic    is_readout;
    } dp_stat_t;

endpackage

>>> rtl/bole_ram.sv
// ----------------------------------------------------------------------------
// bole_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bole_dp.sv
// ----------------------------------------------------------------------------
// bole_dp
// Datapath of the list engine: item registers, element count, the shift
// engine that moves stored elements one place up or down, the scan logic
// for search and read-out, and the result output register.
// ----------------------------------------------------------------------------
module bole_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bole_pkg::dp_cmd_t              cmd,
    output bole_pkg::dp_stat_t             stat,
    input  logic [bole_pkg::CODE_W-1:0]    in_op,
    input  logic signed [bole_pkg::VALUE_W-1:0] in_value,
    input  logic [bole_pkg::POS_W-1:0]     in_position,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bole_pkg::CODE_W-1:0]    out_status,
    output logic signed [bole_pkg::VALUE_W-1:0] out_value,
    output logic [bole_pkg::POS_W-1:0]     out_position,
    output logic                           out_last
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = 8;

    // Item registers.
    bole_pkg::op_t                      op_reg;
    logic signed [bole_pkg::VALUE_W-1:0] val_reg;
    logic [bole_pkg::POS_W-1:0]          pos_reg;

    // List state.
    logic [CW-1:0] count_reg, count_next;

    // Shift engine.
    logic [AW-1:0] src_reg, src_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic [AW-1:0] tgt_reg, tgt_next;
    logic [CW-1:0] mv_left_reg, mv_left_next;
    logic          rdv_reg, rdv_next;
    logic          up_reg, up_next;

    // Scan state.
    logic [AW-1:0]                  idx_reg, idx_next;
    logic [bole_pkg::EMIT_W-1:0]    emit_cnt_reg, emit_cnt_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [bole_pkg::POS_W-1:0]     pend_pos_reg, pend_pos_next;
    logic                           done_reg, done_next;

    // Output register.
    logic                           out_valid_reg;
    bole_pkg::status_t              out_status_reg;
    logic [bole_pkg::VALUE_W-1:0]   out_value_reg;
    logic [bole_pkg::POS_W-1:0]     out_pos_reg;
    logic                           out_last_reg;

    // Decode results.
    bole_pkg::action_t act;
    bole_pkg::status_t err_st;
    logic [AW-1:0]     tgt;
    logic              full, empty;
    logic [CMPW-1:0]   p8, c8;

    // RAM port signals.
    logic                         ram_we, ram_re;
    logic [AW-1:0]                ram_waddr, ram_raddr;
    logic [bole_pkg::VALUE_W-1:0] ram_wdata, ram_rdata;

    // Scan and emission signals.
    logic                         move_done;
    logic                         last_elem, cap_hit, match, pend_emit;
    logic [bole_pkg::EMIT_W-1:0]  emit_after;
    logic                         emit;
    bole_pkg::status_t            e_st;
    logic [bole_pkg::VALUE_W-1:0] e_val;
    logic [bole_pkg::POS_W-1:0]   e_pos;
    logic                         e_last;

    // Decode the held item against the current element count.
    always_comb
    begin
        full   = (count_reg == CW'(CAPACITY));
        empty  = (count_reg == '0);
        p8     = CMPW'(pos_reg);
        c8     = CMPW'(count_reg);
        act    = bole_pkg::ACT_ERR;
        err_st = bole_pkg::STAT_OK;
        tgt    = '0;
        case (op_reg)
            bole_pkg::OP_PUSH_FRONT, bole_pkg::OP_PUSH_BACK:
            begin
                tgt = (op_reg == bole_pkg::OP_PUSH_FRONT) ? '0 : AW'(count_reg);
                if (full)
                begin
                    err_st = bole_pkg::STAT_FULL;
                end
                else
                begin
                    act = bole_pkg::ACT_INSERT;
                end
            end
            bole_pkg::OP_INSERT_AFTER:
            begin
                tgt = AW'(pos_reg);
                if (full)
                begin
                    err_st = bole_pkg::STAT_FULL;
                end
                else if (pos_reg == '0)
                begin
                    err_st = bole_pkg::STAT_BADPOS;
                end
                else if (empty)
                begin
                    err_st = bole_pkg::STAT_EMPTY;
                end
                else if (p8 > c8)
                begin
                    err_st = bole_pkg::STAT_BADPOS;
                end
                else
                begin
                    act = bole_pkg::ACT_INSERT;
                end
            end
            bole_pkg::OP_POP_FRONT, bole_pkg::OP_POP_BACK:
            begin
                tgt = (op_reg == bole_pkg::OP_POP_FRONT) ? '0 :
                      AW'(count_reg - CW'(1));
                if (empty)
                begin
                    err_st = bole_pkg::STAT_EMPTY;
                end
                else
                begin
                    act = bole_pkg::ACT_REMOVE;
                end
            end
            bole_pkg::OP_DELETE_AFTER:
            begin
                tgt = AW'(pos_reg);
                if (empty)
                begin
                    err_st = bole_pkg::STAT_EMPTY;
                end
                else if (pos_reg == '0 || p8 >= c8)
                begin
                    err_st = bole_pkg::STAT_BADPOS;
                end
                else
                begin
                    act = bole_pkg::ACT_REMOVE;
                end
            end
            default:
            begin
                if (empty)
                begin
                    err_st = bole_pkg::STAT_EMPTY;
                end
                else
                begin
                    act = bole_pkg::ACT_SCAN;
                end
            end
        endcase
    end

    // Scan conditions for the element whose read data is now valid.
    assign move_done  = (mv_left_reg == '0) && !rdv_reg;
    assign last_elem  = (idx_reg == AW'(count_reg - CW'(1)));
    assign cap_hit    = (emit_cnt_reg == bole_pkg::EMIT_W'(bole_pkg::MAX_RESULTS - 1));
    assign match      = (ram_rdata == val_reg);
    assign pend_emit  = match && pend_valid_reg;
    assign emit_after = emit_cnt_reg + bole_pkg::EMIT_W'(pend_emit);

    // Element store.
    bole_ram #(
        .WIDTH (bole_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // RAM port selection: shift engine writes and reads, scan reads.
    always_comb
    begin
        ram_we    = cmd.move && (rdv_reg || (move_done && up_reg));
        ram_waddr = rdv_reg ? wa_reg : tgt_reg;
        ram_wdata = rdv_reg ? ram_rdata : val_reg;
        ram_re    = (cmd.move && (mv_left_reg != '0)) || cmd.scan_read;
        ram_raddr = cmd.move ? src_reg : idx_reg;
    end

    // Next state of count, shift engine and scan registers.
    always_comb
    begin
        count_next      = count_reg;
        src_next        = src_reg;
        wa_next         = wa_reg;
        tgt_next        = tgt_reg;
        mv_left_next    = mv_left_reg;
        rdv_next        = rdv_reg;
        up_next         = up_reg;
        idx_next        = idx_reg;
        emit_cnt_next   = emit_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        done_next       = done_reg;

        if (cmd.load)
        begin
            idx_next        = '0;
            emit_cnt_next   = '0;
            pend_valid_next = 1'b0;
            done_next       = 1'b0;
        end

        // Set up a shift: up opens a gap at the target, down closes one there.
        if (cmd.move_start)
        begin
            up_next  = (act == bole_pkg::ACT_INSERT);
            tgt_next = tgt;
            rdv_next = 1'b0;
            if (act == bole_pkg::ACT_INSERT)
            begin
                mv_left_next = count_reg - CW'(tgt);
                src_next     = AW'(count_reg - CW'(1));
            end
            else
            begin
                mv_left_next = count_reg - CW'(1) - CW'(tgt);
                src_next     = tgt + AW'(1);
            end
        end

        // One shift step: read the next source, write the previous one.
        if (cmd.move)
        begin
            if (mv_left_reg != '0)
            begin
                rdv_next     = 1'b1;
                wa_next      = up_reg ? src_reg + AW'(1) : src_reg - AW'(1);
                src_next     = up_reg ? src_reg - AW'(1) : src_reg + AW'(1);
                mv_left_next = mv_left_reg - CW'(1);
            end
            else
            begin
                rdv_next = 1'b0;
                if (!rdv_reg)
                begin
                    count_next = up_reg ? count_reg + CW'(1) : count_reg - CW'(1);
                end
            end
        end

        // One scan step over the element just read.
        if (cmd.scan_step)
        begin
            idx_next = idx_reg + AW'(1);
            if (op_reg == bole_pkg::OP_READ_OUT)
            begin
                emit_cnt_next = emit_cnt_reg + bole_pkg::EMIT_W'(1);
                done_next     = last_elem || cap_hit;
            end
            else
            begin
                emit_cnt_next = emit_after;
                if (match)
                begin
                    pend_valid_next = 1'b1;
                    pend_pos_next   = bole_pkg::POS_W'(idx_reg) + bole_pkg::POS_W'(1);
                end
                done_next = last_elem || ((match || pend_valid_reg) &&
                            (emit_after ==
                             bole_pkg::EMIT_W'(bole_pkg::MAX_RESULTS - 1)));
            end
        end
    end

    // Result selection for the output register.
    always_comb
    begin
        emit   = 1'b0;
        e_st   = bole_pkg::STAT_OK;
        e_val  = '0;
        e_pos  = '0;
        e_last = 1'b1;
        if (cmd.emit_err)
        begin
            emit = 1'b1;
            e_st = err_st;
        end
        if (cmd.move && move_done)
        begin
            emit = 1'b1;
        end
        if (cmd.scan_step)
        begin
            if (op_reg == bole_pkg::OP_READ_OUT)
            begin
                emit   = 1'b1;
                e_val  = ram_rdata;
                e_last = last_elem || cap_hit;
            end
            else if (pend_emit)
            begin
                emit   = 1'b1;
                e_pos  = pend_pos_reg;
                e_last = 1'b0;
            end
        end
        if (cmd.emit_final)
        begin
            emit = 1'b1;
            if (pend_valid_reg)
            begin
                e_pos = pend_pos_reg;
            end
            else
            begin
                e_st = bole_pkg::STAT_NOTFOUND;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            mv_left_reg    <= '0;
            rdv_reg        <= 1'b0;
            up_reg         <= 1'b0;
            emit_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            mv_left_reg    <= mv_left_next;
            rdv_reg        <= rdv_next;
            up_reg         <= up_next;
            emit_cnt_reg   <= emit_cnt_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= bole_pkg::op_t'(in_op);
            val_reg <= in_value;
            pos_reg <= in_position;
        end
        src_reg      <= src_next;
        wa_reg       <= wa_next;
        tgt_reg      <= tgt_next;
        idx_reg      <= idx_next;
        pend_pos_reg <= pend_pos_next;
        if (emit)
        begin
            out_status_reg <= e_st;
            out_value_reg  <= e_val;
            out_pos_reg    <= e_pos;
            out_last_reg   <= e_last;
        end
    end

    // Status to the controller.
    always_comb
    begin
        stat.act        = act;
        stat.move_done  = move_done;
        stat.out_busy   = out_valid_reg;
        stat.scan_done  = done_reg;
        stat.is_readout = (op_reg == bole_pkg::OP_READ_OUT);
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_value    = out_value_reg;
    assign out_position = out_pos_reg;
    assign out_last     = out_last_reg;

endmodule

>>> rtl/bole_ctrl.sv
// ----------------------------------------------------------------------------
// bole_ctrl
// Controller of the list engine: accepts one item at a time and sequences
// the datapath through decode, element shifting, scanning and result beats.
// ----------------------------------------------------------------------------
module bole_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bole_pkg::dp_stat_t  stat,
    output bole_pkg::dp_cmd_t   cmd
);

    bole_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bole_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            bole_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = bole_pkg::S_DECODE;
                end
            end
            bole_pkg::S_DECODE:
            begin
                case (stat.act)
                    bole_pkg::ACT_INSERT, bole_pkg::ACT_REMOVE:
                    begin
                        cmd.move_start = 1'b1;
                        state_next     = bole_pkg::S_MOVE;
                    end
                    bole_pkg::ACT_SCAN:
                    begin
                        cmd.scan_read = 1'b1;
                        state_next    = bole_pkg::S_SCAN_CHK;
                    end
                    default:
                    begin
                        cmd.emit_err = 1'b1;
                        state_next   = bole_pkg::S_RESP;
                    end
                endcase
            end
            bole_pkg::S_MOVE:
            begin
                cmd.move = 1'b1;
                if (stat.move_done)
                begin
                    state_next = bole_pkg::S_RESP;
                end
            end
            bole_pkg::S_SCAN_CHK:
            begin
                cmd.scan_step = 1'b1;
                state_next    = bole_pkg::S_SCAN_WAIT;
            end
            bole_pkg::S_SCAN_WAIT:
            begin
                if (!stat.out_busy)
                begin
                    if (!stat.scan_done)
                    begin
                        cmd.scan_read = 1'b1;
                        state_next    = bole_pkg::S_SCAN_CHK;
                    end
                    else if (stat.is_readout)
                    begin
                        state_next = bole_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = bole_pkg::S_FINAL;
                    end
                end
            end
            bole_pkg::S_FINAL:
            begin
                cmd.emit_final = 1'b1;
                state_next     = bole_pkg::S_RESP;
            end
            bole_pkg::S_RESP:
            begin
                if (!stat.out_busy)
                begin
                    state_next = bole_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bole_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/bounded_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// Ordered list of up to CAPACITY signed 32-bit values with front, back and
// positional insert and delete, search and read-out.
//
//   Channel  Dir  Signals                            Contents
//   s_*      in   s_tvalid s_tready s_tdata s_tuser  one operation per beat
//   m_*      out  m_tvalid m_tready m_tdata m_tuser  result beats, m_tlast
//                 m_tlast                            marks an item's final beat
//
// One item is worked at a time; the next waits until every beat has left.
// An error sends one beat; an insert or delete first shifts elements one
// place through the single read port of the element RAM to open or close
// a gap at its target. A scan reads the elements one by one and waits on
// each beat it sends; a search adds a final beat. A stalled m_tready holds
// the engine until the beat is taken. Reset empties the list at once; the
// element RAM needs no clearing.
module bounded_ordered_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[38:32], zero[39]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // value_out[31:0], found_position[38:32], zero[39]
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast
);

    bole_pkg::dp_cmd_t  cmd;
    bole_pkg::dp_stat_t stat;

    logic signed [bole_pkg::VALUE_W-1:0] value_out;
    logic [bole_pkg::POS_W-1:0]          found_position;

    // Sequencing.
    bole_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage, shifting, scanning and the result register.
    bole_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_op        (s_tuser),
        .in_value     (s_tdata[31:0]),
        .in_position  (s_tdata[38:32]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (m_tuser),
        .out_value    (value_out),
        .out_position (found_position),
        .out_last     (m_tlast)
    );

    // Result beat packing.
    assign m_tdata = {1'b0, found_position, value_out};

`ifndef NO_ASSERTIONS
    // The engine only takes an item once every result beat has left.
    a_ready_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result beat is pending");

    // An accepted item passes through decode before its first result.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (!m_tvalid && !s_tready))
        else $error("result or new item directly after accept");

    // At most one load or emission command is issued per cycle.
    a_single_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.emit_err, cmd.scan_step, cmd.emit_final}))
        else $error("conflicting datapath commands");
`endif

endmodule
